// File: rtl/bbd_pkg.sv
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared types, register codes and lookup tables for the Bayer demosaic.
// ----------------------------------------------------------------------------
package bbd_pkg;

    localparam int CHAN_BITS      = 16;
    localparam int WIDTH_BITS     = 13;
    localparam int HEIGHT_BITS    = 16;
    localparam int PAT_BITS       = 2;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int WT_BITS        = 4;
    localparam int FACTOR_BITS    = 25;
    localparam int RECIP_SHIFT    = 24;
    localparam int MIN_DIM        = 3;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET   = 13'd640;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET  = 16'd480;
    localparam logic [PAT_BITS-1:0]    PATTERN_RESET = 2'd0;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CFA_PATTERN  = 2'd2;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_FLUSH  = 1'b1;

    localparam logic [1:0] COL_RED   = 2'd0;
    localparam logic [1:0] COL_GREEN = 2'd1;
    localparam logic [1:0] COL_BLUE  = 2'd2;

    localparam logic [PAT_BITS-1:0] PAT_BGGR = 2'd0;
    localparam logic [PAT_BITS-1:0] PAT_GRBG = 2'd1;
    localparam logic [PAT_BITS-1:0] PAT_GBRG = 2'd2;
    localparam logic [PAT_BITS-1:0] PAT_RGGB = 2'd3;

    typedef struct packed {
        logic valid;
        logic eof;
        logic top_ok;
        logic mid_row_ok;
        logic bot_ok;
        logic left_ok;
        logic mid_col_ok;
        logic right_ok;
        logic row_par;
        logic col_par;
    } pix_ctl_t;

    function automatic logic [1:0] cfa_color(input logic [PAT_BITS-1:0] pat,
                                             input logic rpar, input logic cpar);
        logic [1:0] col;
        col = COL_GREEN;
        case ({pat, rpar, cpar})
            {PAT_BGGR, 2'b00}: col = COL_BLUE;
            {PAT_BGGR, 2'b11}: col = COL_RED;
            {PAT_GRBG, 2'b01}: col = COL_RED;
            {PAT_GRBG, 2'b10}: col = COL_BLUE;
            {PAT_GBRG, 2'b01}: col = COL_BLUE;
            {PAT_GBRG, 2'b10}: col = COL_RED;
            {PAT_RGGB, 2'b00}: col = COL_RED;
            {PAT_RGGB, 2'b11}: col = COL_BLUE;
            default:           col = COL_GREEN;
        endcase
        return col;
    endfunction

    // (256 / weight) << 16, used with a right shift of RECIP_SHIFT
    function automatic logic [FACTOR_BITS-1:0] interior_factor(input logic [WT_BITS-1:0] w);
        logic [FACTOR_BITS-1:0] f;
        case (w)
            4'd1:    f = 25'd256 << 16;
            4'd2:    f = 25'd128 << 16;
            4'd3:    f = 25'd85  << 16;
            4'd4:    f = 25'd64  << 16;
            4'd5:    f = 25'd51  << 16;
            4'd6:    f = 25'd42  << 16;
            4'd7:    f = 25'd36  << 16;
            4'd8:    f = 25'd32  << 16;
            4'd9:    f = 25'd28  << 16;
            4'd10:   f = 25'd25  << 16;
            4'd11:   f = 25'd23  << 16;
            4'd12:   f = 25'd21  << 16;
            default: f = '0;
        endcase
        return f;
    endfunction

    // ceil(2^24 / count): exact floor division for sums below 2^20
    function automatic logic [FACTOR_BITS-1:0] border_factor(input logic [WT_BITS-1:0] w);
        logic [FACTOR_BITS-1:0] f;
        case (w)
            4'd1:    f = 25'd16777216;
            4'd2:    f = 25'd8388608;
            4'd3:    f = 25'd5592406;
            4'd4:    f = 25'd4194304;
            4'd5:    f = 25'd3355444;
            4'd6:    f = 25'd2796203;
            4'd7:    f = 25'd2396746;
            4'd8:    f = 25'd2097152;
            4'd9:    f = 25'd1864136;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

// File: rtl/bayer_bilinear_demosaic.sv
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic
// Pipeline: b_, p_, q_ and x_ registers, then the output register; a pixel
// trails its raw sample by one row and one column of input requests.
// Throughput: one request per cycle; the line store is read and written back
// once per request, and s_tready drops only while a result waits at m_.
// Reset: counters and valid bits clear, registers go to 640x480 BGGR. The
// line store is not swept: rows above the frame never reach a pixel.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic
    import bbd_pkg::*;
#(
    parameter int MAX_WIDTH   = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [CHAN_BITS-1:0]        s_tdata,   // raw_sample
    input  logic                        s_tuser,   // mode
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [3*CHAN_BITS-1:0]      m_tdata,   // red, green, blue
    output logic                        m_tlast,   // end_of_frame
    input  logic                        cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]    cfg_wdata
);

    localparam int AW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMP_W = (AW + 1 > WIDTH_BITS) ? AW + 1 : WIDTH_BITS;
    localparam int ROW_W = HEIGHT_BITS + 1;

    logic [WIDTH_BITS-1:0]  frame_width_reg,  frame_width_next;
    logic [HEIGHT_BITS-1:0] frame_height_reg, frame_height_next;
    logic [PAT_BITS-1:0]    cfa_pattern_reg,  cfa_pattern_next;
    logic [AW-1:0]          in_col_reg,  in_col_next;
    logic [ROW_W-1:0]       in_row_reg,  in_row_next;
    logic [AW-1:0]          out_col_reg, out_col_next;
    logic [HEIGHT_BITS-1:0] out_row_reg, out_row_next;

    logic                   en;
    logic                   act;
    logic                   draining;
    logic                   finishing;
    logic                   emit_pre;
    logic                   emit_post;
    logic                   emit;
    logic                   do_write;
    logic                   cfg_restart;
    logic                   in_col_wrap;
    logic                   out_col_last;
    logic                   out_row_last;
    logic [CMP_W-1:0]       width_cmp;
    logic [ROW_W-1:0]       height_ext;
    logic [SAMPLE_BITS-1:0] sample_in;
    pix_ctl_t               ctl_in;

    logic [2*SAMPLE_BITS-1:0] line_mem [MAX_WIDTH];
    logic [2*SAMPLE_BITS-1:0] rd_data_reg;
    logic [SAMPLE_BITS-1:0]   rd_up;
    logic [SAMPLE_BITS-1:0]   rd_mid;

    pix_ctl_t                 b_ctl_reg;
    logic                     b_write_reg;
    logic                     b_post_reg;
    logic [AW-1:0]            b_addr_reg;
    logic [SAMPLE_BITS-1:0]   b_sample_reg;

    logic [2:0][SAMPLE_BITS-1:0]      win1_reg, win2_reg;
    logic [2:0][SAMPLE_BITS-1:0]      new_col;
    pix_ctl_t                         p_ctl_reg;
    logic [2:0][2:0][SAMPLE_BITS-1:0] p_win_reg;

    logic                        calc_valid;
    logic                        calc_eof;
    logic [2:0][CHAN_BITS-1:0]   calc_rgb;

    logic                        m_tvalid_reg;
    logic [3*CHAN_BITS-1:0]      m_tdata_reg;
    logic                        m_tlast_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    assign width_cmp    = CMP_W'(frame_width_reg);
    assign height_ext   = ROW_W'(frame_height_reg);
    assign draining     = in_row_reg >= height_ext;
    assign finishing    = in_row_reg > height_ext;
    assign in_col_wrap  = (CMP_W'(in_col_reg) + CMP_W'(1)) >= width_cmp;
    assign out_col_last = (CMP_W'(out_col_reg) + CMP_W'(1)) >= width_cmp;
    assign out_row_last = (ROW_W'(out_row_reg) + ROW_W'(1)) >= height_ext;

    assign act       = s_tvalid && en && !(s_tuser == MODE_FLUSH && !draining);
    assign emit_pre  = !finishing && in_col_reg == '0 && in_row_reg >= ROW_W'(2);
    assign emit_post = !finishing && in_col_reg != '0 && in_row_reg != '0;
    assign emit      = act && (finishing || emit_pre || emit_post);
    assign do_write  = act && !finishing;
    assign sample_in = draining ? '0 : s_tdata[SAMPLE_BITS-1:0];

    always_comb begin
        ctl_in.valid      = emit;
        ctl_in.eof        = finishing || (out_row_last && out_col_last);
        ctl_in.top_ok     = out_row_reg != '0;
        ctl_in.mid_row_ok = ROW_W'(out_row_reg) < height_ext;
        ctl_in.bot_ok     = !out_row_last;
        ctl_in.left_ok    = out_col_reg != '0;
        ctl_in.mid_col_ok = CMP_W'(out_col_reg) < width_cmp;
        ctl_in.right_ok   = !out_col_last;
        ctl_in.row_par    = out_row_reg[0];
        ctl_in.col_par    = out_col_reg[0];
    end

    always_comb begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        cfa_pattern_next  = cfa_pattern_reg;
        in_col_next       = in_col_reg;
        in_row_next       = in_row_reg;
        out_col_next      = out_col_reg;
        out_row_next      = out_row_reg;
        cfg_restart       = 1'b0;
        if (cfg_we) begin
            case (cfg_index)
                REG_FRAME_WIDTH: begin
                    cfg_restart = 1'b1;
                    if (cfg_wdata[WIDTH_BITS-1:0] < WIDTH_BITS'(MIN_DIM)) begin
                        frame_width_next = WIDTH_BITS'(MIN_DIM);
                    end else if (int'(cfg_wdata[WIDTH_BITS-1:0]) > MAX_WIDTH) begin
                        frame_width_next = WIDTH_BITS'(MAX_WIDTH);
                    end else begin
                        frame_width_next = cfg_wdata[WIDTH_BITS-1:0];
                    end
                end
                REG_FRAME_HEIGHT: begin
                    cfg_restart = 1'b1;
                    if (cfg_wdata[HEIGHT_BITS-1:0] < HEIGHT_BITS'(MIN_DIM)) begin
                        frame_height_next = HEIGHT_BITS'(MIN_DIM);
                    end else begin
                        frame_height_next = cfg_wdata[HEIGHT_BITS-1:0];
                    end
                end
                REG_CFA_PATTERN: begin
                    cfg_restart      = 1'b1;
                    cfa_pattern_next = cfg_wdata[PAT_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
        if (cfg_restart || (act && finishing)) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end else if (act) begin
            if (in_col_wrap) begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end else begin
                in_col_next = in_col_reg + AW'(1);
            end
            if (emit) begin
                if (out_col_last) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + HEIGHT_BITS'(1);
                end else begin
                    out_col_next = out_col_reg + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
            cfa_pattern_reg  <= PATTERN_RESET;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
        end else begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            cfa_pattern_reg  <= cfa_pattern_next;
            in_col_reg       <= in_col_next;
            in_row_reg       <= in_row_next;
            out_col_reg      <= out_col_next;
            out_row_reg      <= out_row_next;
        end
    end

    // Line store: low half the row two above, high half the row above.
    // Consecutive requests hit different columns, so no forwarding is needed.
    assign rd_up  = rd_data_reg[SAMPLE_BITS-1:0];
    assign rd_mid = rd_data_reg[2*SAMPLE_BITS-1:SAMPLE_BITS];

    always_ff @(posedge aclk) begin
        if (en) begin
            rd_data_reg <= line_mem[in_col_reg];
            if (b_write_reg) begin
                line_mem[b_addr_reg] <= {b_sample_reg, rd_mid};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_ctl_reg   <= '0;
            b_write_reg <= 1'b0;
            p_ctl_reg   <= '0;
        end else if (en) begin
            b_ctl_reg   <= ctl_in;
            b_write_reg <= do_write;
            p_ctl_reg   <= b_ctl_reg;
        end
    end

    assign new_col = {b_sample_reg, rd_mid, rd_up};

    always_ff @(posedge aclk) begin
        if (en) begin
            b_post_reg   <= emit_post;
            b_addr_reg   <= in_col_reg;
            b_sample_reg <= sample_in;
            p_win_reg[0] <= win1_reg;
            p_win_reg[1] <= win2_reg;
            p_win_reg[2] <= b_post_reg ? new_col : '0;
            if (b_write_reg) begin
                win1_reg <= win2_reg;
                win2_reg <= new_col;
            end
        end
    end

    bbd_pixel_calc #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_pixel_calc (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .cfa_pattern (cfa_pattern_reg),
        .in_ctl      (p_ctl_reg),
        .in_win      (p_win_reg),
        .out_valid   (calc_valid),
        .out_eof     (calc_eof),
        .out_rgb     (calc_rgb)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= calc_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= calc_rgb;
            m_tlast_reg <= calc_eof;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// File: rtl/bbd_pixel_calc.sv
// ----------------------------------------------------------------------------
// bbd_pixel_calc
// Per-colour weighted sums over a 3x3 window, then reciprocal multiply; the pixel's own colour takes the centre sample.
// ----------------------------------------------------------------------------
module bbd_pixel_calc
    import bbd_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic [PAT_BITS-1:0]                  cfa_pattern,
    input  pix_ctl_t                             in_ctl,
    input  logic [2:0][2:0][SAMPLE_BITS-1:0]     in_win,
    output logic                                 out_valid,
    output logic                                 out_eof,
    output logic [2:0][CHAN_BITS-1:0]            out_rgb
);

    localparam int SUM_W  = SAMPLE_BITS + 4;
    localparam int PROD_W = SUM_W + FACTOR_BITS;

    logic [2:0][SUM_W-1:0]       sum_c;
    logic [2:0][WT_BITS-1:0]     wt_c;
    logic [2:0][FACTOR_BITS-1:0] factor_c;
    logic [2:0]                  row_ok;
    logic [2:0]                  col_ok;
    logic                        interior;
    logic [1:0]                  own_col;

    pix_ctl_t                    q_ctl_reg;
    logic [2:0][SUM_W-1:0]       q_sum_reg;
    logic [2:0][FACTOR_BITS-1:0] q_factor_reg;
    logic [1:0]                  q_own_reg;
    logic [SAMPLE_BITS-1:0]      q_center_reg;

    pix_ctl_t                    x_ctl_reg;
    logic [2:0][PROD_W-1:0]      x_prod_reg;
    logic [1:0]                  x_own_reg;
    logic [SAMPLE_BITS-1:0]      x_center_reg;

    assign row_ok   = {in_ctl.bot_ok, in_ctl.mid_row_ok, in_ctl.top_ok};
    assign col_ok   = {in_ctl.right_ok, in_ctl.mid_col_ok, in_ctl.left_ok};
    assign interior = in_ctl.top_ok & in_ctl.bot_ok & in_ctl.left_ok & in_ctl.right_ok;
    assign own_col  = cfa_color(cfa_pattern, in_ctl.row_par, in_ctl.col_par);

    always_comb begin
        sum_c = '0;
        wt_c  = '0;
        for (int c = 0; c < 3; c++) begin
            for (int dy = 0; dy < 3; dy++) begin
                for (int dx = 0; dx < 3; dx++) begin
                    if (row_ok[dy] && col_ok[dx] &&
                        cfa_color(cfa_pattern, in_ctl.row_par ^ (dy != 1),
                                  in_ctl.col_par ^ (dx != 1)) == 2'(c)) begin
                        if (interior) begin
                            if (!(dy == 1 && dx == 1)) begin
                                sum_c[c] = sum_c[c] + (SUM_W'(in_win[dx][dy])
                                           << ((dy == 1) + (dx == 1)));
                                wt_c[c]  = wt_c[c] + (WT_BITS'(1)
                                           << ((dy == 1) + (dx == 1)));
                            end
                        end else begin
                            sum_c[c] = sum_c[c] + SUM_W'(in_win[dx][dy]);
                            wt_c[c]  = wt_c[c] + WT_BITS'(1);
                        end
                    end
                end
            end
            factor_c[c] = interior ? interior_factor(wt_c[c]) : border_factor(wt_c[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_ctl_reg <= '0;
            x_ctl_reg <= '0;
        end else if (en) begin
            q_ctl_reg <= in_ctl;
            x_ctl_reg <= q_ctl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_sum_reg    <= sum_c;
            q_factor_reg <= factor_c;
            q_own_reg    <= own_col;
            q_center_reg <= in_win[1][1];
            for (int c = 0; c < 3; c++) begin
                x_prod_reg[c] <= PROD_W'(q_sum_reg[c]) * PROD_W'(q_factor_reg[c]);
            end
            x_own_reg    <= q_own_reg;
            x_center_reg <= q_center_reg;
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (x_own_reg == 2'(c)) begin
                out_rgb[c] = CHAN_BITS'(x_center_reg);
            end else begin
                out_rgb[c] = CHAN_BITS'(x_prod_reg[c][RECIP_SHIFT +: SAMPLE_BITS]);
            end
        end
    end

    assign out_valid = x_ctl_reg.valid;
    assign out_eof   = x_ctl_reg.eof;

endmodule

// File: rtl/bbd_checker.sv
// ----------------------------------------------------------------------------
// bbd_checker
// Port-level checks on the demosaic's request and result channels.
// ----------------------------------------------------------------------------
module bbd_checker
    import bbd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [3*CHAN_BITS-1:0] m_tdata,
    input  logic                   m_tlast
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_valid_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_tvalid) |-> $past(m_tready))
        else $error("result withdrawn without being taken");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("request side stalled without output backpressure");

endmodule

bind bayer_bilinear_demosaic bbd_checker u_bbd_checker (.*);
